// ===== hw/rtl/mfg_pkg.sv =====
// Shared types and constants of the monomial feature generator.
`timescale 1ns / 1ps

package mfg_pkg;

    // Field widths of the transfer channels
    localparam int IN_W      = 32;
    localparam int VAL_W     = 48;
    localparam int EXP_W     = 3;
    localparam int SUM_W     = 5;
    localparam int FRAC_BITS = 30;

    // Shared multiplier: 48x48 magnitudes built from four 24x24 partial products
    localparam int MAG_W     = 48;
    localparam int HALF_W    = MAG_W / 2;
    localparam int PP_W      = 2 * HALF_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int MAGF_W    = PROD_W - FRAC_BITS;
    localparam int PART_W    = 2;
    localparam int SHIFT_W   = 2;

    localparam logic [PART_W-1:0]  LAST_PART = '1;
    localparam logic [MAGF_W-1:0]  LIM_NEG   = MAGF_W'(1) << (VAL_W - 1);
    localparam logic [MAGF_W-1:0]  LIM_POS   = LIM_NEG - MAGF_W'(1);
    localparam logic [VAL_W-1:0]   ONE_VAL   = VAL_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0]  ACC_INIT  = PROD_W'(1) << (FRAC_BITS - 1);

    // Odd phi exponent needs theta exponent in [lo, hi] and y exponent <= max
    localparam logic [EXP_W-1:0] THETA_ODD_LO = EXP_W'(1);
    localparam logic [EXP_W-1:0] THETA_ODD_HI = EXP_W'(2);
    localparam logic [EXP_W-1:0] Y_ODD_MAX    = EXP_W'(1);

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_FINISH
    } mfg_state_t;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              start;
        logic              setup;
        logic              mul;
        logic [PART_W-1:0] part;
        logic              acc;
        logic              fin;
        logic              search_step;
        logic              out_load;
    } mfg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic steps_left;
        logic search_done;
        logic exhausted;
    } mfg_status_t;

endpackage

// ===== hw/rtl/monomial_feature_generator_core.sv =====
// Top level of the monomial feature generator: controller, datapath and checks.
`timescale 1ns / 1ps

// A load transfer (command 0) stores x, theta, y and phi and rewinds the term
// cursor. Each next-term transfer (command 1) yields one monomial with its
// exponents, in ascending (x, theta, y, phi) exponent order, with last_term on
// the final one and saturated when any product step clipped. One 24x24
// multiplier is shared: each unit of exponent runs through setup, four partial
// products, accumulate, round/clip and a check; the cursor search for the
// following term scans one candidate tuple per cycle in parallel and can
// stretch short terms. A pull before any load or after the last term is taken
// and yields nothing. A finished result waits in an output register, and a
// load may be taken while it waits.
module monomial_feature_generator_core #(
    parameter int MAX_EXP     = 5,
    parameter int MAX_ORDER   = 7,
    parameter int COORD_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic signed [mfg_pkg::IN_W-1:0]  s_x_in,
    input  logic signed [mfg_pkg::IN_W-1:0]  s_theta_in,
    input  logic signed [mfg_pkg::IN_W-1:0]  s_y_in,
    input  logic signed [mfg_pkg::IN_W-1:0]  s_phi_in,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [mfg_pkg::VAL_W-1:0] m_term_value,
    output logic        [mfg_pkg::EXP_W-1:0] m_exp_x,
    output logic        [mfg_pkg::EXP_W-1:0] m_exp_theta,
    output logic        [mfg_pkg::EXP_W-1:0] m_exp_y,
    output logic        [mfg_pkg::EXP_W-1:0] m_exp_phi,
    output logic                             m_last_term,
    output logic                             m_saturated
);
    import mfg_pkg::*;

    mfg_cmd_t    cmd;
    mfg_status_t status;

    mfg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mfg_datapath #(
        .MAX_EXP     (MAX_EXP),
        .MAX_ORDER   (MAX_ORDER),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .status     (status),
        .x_in       (s_x_in),
        .theta_in   (s_theta_in),
        .y_in       (s_y_in),
        .phi_in     (s_phi_in),
        .term_value (m_term_value),
        .exp_x      (m_exp_x),
        .exp_theta  (m_exp_theta),
        .exp_y      (m_exp_y),
        .exp_phi    (m_exp_phi),
        .last_term  (m_last_term),
        .saturated  (m_saturated)
    );

    // The block is ready again in the cycle after a load transfer
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_LOAD) |=> s_ready)
        else $error("block not ready after a load transfer");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten while pending");

    // Term work starts only on an accepted next-term transfer
    a_start_on_pull: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (s_valid && s_ready && s_command == CMD_NEXT))
        else $error("term started without a next-term transfer");

    // A result appears the cycle after it is handed off
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("handed-off result not presented");

endmodule

// ===== hw/rtl/mfg_datapath.sv =====
// Datapath: coordinate store, term cursor search, shared multiplier and result register.
`timescale 1ns / 1ps

module mfg_datapath #(
    parameter int MAX_EXP     = 5,
    parameter int MAX_ORDER   = 7,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                aclk,
    input  mfg_pkg::mfg_cmd_t                   cmd,
    output mfg_pkg::mfg_status_t                status,
    input  logic signed [mfg_pkg::IN_W-1:0]     x_in,
    input  logic signed [mfg_pkg::IN_W-1:0]     theta_in,
    input  logic signed [mfg_pkg::IN_W-1:0]     y_in,
    input  logic signed [mfg_pkg::IN_W-1:0]     phi_in,
    output logic signed [mfg_pkg::VAL_W-1:0]    term_value,
    output logic        [mfg_pkg::EXP_W-1:0]    exp_x,
    output logic        [mfg_pkg::EXP_W-1:0]    exp_theta,
    output logic        [mfg_pkg::EXP_W-1:0]    exp_y,
    output logic        [mfg_pkg::EXP_W-1:0]    exp_phi,
    output logic                                last_term,
    output logic                                saturated
);
    import mfg_pkg::*;

    localparam int KEEP_W = (COORD_WIDTH < IN_W) ? COORD_WIDTH : IN_W;

    // Index 3 is x, 2 theta, 1 y, 0 phi
    typedef logic [3:0][EXP_W-1:0] exps_t;

    function automatic logic is_term(input exps_t e);
        logic             in_range;
        logic [SUM_W-1:0] total;
        logic             odd_ok;
        in_range = 1'b1;
        total    = '0;
        for (int k = 0; k < 4; k++) begin
            if (e[k] > EXP_W'(MAX_EXP)) begin
                in_range = 1'b0;
            end
            total = total + SUM_W'(e[k]);
        end
        odd_ok = !e[0][0] ||
                 ((e[2] == THETA_ODD_LO || e[2] == THETA_ODD_HI) && (e[1] <= Y_ODD_MAX));
        return in_range && (total <= SUM_W'(MAX_ORDER)) && odd_ok;
    endfunction

    logic signed [COORD_WIDTH-1:0] coord_reg [4];
    exps_t                         cursor_reg;
    exps_t                         term_reg;
    exps_t                         rem_reg;
    exps_t                         cand_reg;
    logic                          found_reg;
    logic                          exh_reg;
    logic [VAL_W-1:0]              val_reg;
    logic                          sat_reg;
    logic [MAG_W-1:0]              a_mag_reg;
    logic [MAG_W-1:0]              b_mag_reg;
    logic                          neg_reg;
    logic [PP_W-1:0]               pp_reg;
    logic [SHIFT_W-1:0]            pp_shift_reg;
    logic [PROD_W-1:0]             acc_reg;

    logic [VAL_W-1:0]              out_val_reg;
    exps_t                         out_exp_reg;
    logic                          out_last_reg;
    logic                          out_sat_reg;

    logic signed [KEEP_W-1:0]      keep_in [4];
    logic [1:0]                    sel;
    logic [COORD_WIDTH-1:0]        csel;
    logic [COORD_WIDTH-1:0]        cmag;
    logic [VAL_W-1:0]              vmag;
    exps_t                         cand_inc;
    logic                          cand_wrap;
    logic [HALF_W-1:0]             a_half;
    logic [HALF_W-1:0]             b_half;
    logic [PP_W-1:0]               pp_next;
    logic [SHIFT_W-1:0]            shift_next;
    logic [PROD_W-1:0]             pp_aligned;
    logic [MAGF_W-1:0]             mag_full;
    logic [MAGF_W-1:0]             lim;
    logic                          over;
    logic [VAL_W-1:0]              mag_clip;
    logic [VAL_W-1:0]              fin_val;

    // Reduce the raw inputs to the coordinate width
    assign keep_in[3] = x_in[KEEP_W-1:0];
    assign keep_in[2] = theta_in[KEEP_W-1:0];
    assign keep_in[1] = y_in[KEEP_W-1:0];
    assign keep_in[0] = phi_in[KEEP_W-1:0];

    // Pick the coordinate of the highest-index exponent still pending
    always_comb begin
        sel = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (rem_reg[k] != '0) begin
                sel = 2'(k);
            end
        end
    end

    assign csel = coord_reg[sel];
    assign cmag = csel[COORD_WIDTH-1] ? (~csel + COORD_WIDTH'(1)) : csel;
    assign vmag = val_reg[VAL_W-1] ? (~val_reg + VAL_W'(1)) : val_reg;

    // Advance the candidate one step in mixed radix, phi least significant
    always_comb begin
        cand_inc  = cand_reg;
        cand_wrap = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (cand_wrap) begin
                if (cand_inc[k] < EXP_W'(MAX_EXP)) begin
                    cand_inc[k] = cand_inc[k] + EXP_W'(1);
                    cand_wrap   = 1'b0;
                end else begin
                    cand_inc[k] = '0;
                end
            end
        end
    end

    // Partial product of the selected halves
    assign a_half     = cmd.part[1] ? a_mag_reg[MAG_W-1:HALF_W] : a_mag_reg[HALF_W-1:0];
    assign b_half     = cmd.part[0] ? b_mag_reg[MAG_W-1:HALF_W] : b_mag_reg[HALF_W-1:0];
    assign pp_next    = a_half * b_half;
    assign shift_next = SHIFT_W'(cmd.part[1]) + SHIFT_W'(cmd.part[0]);

    // Align the registered partial product
    always_comb begin
        case (pp_shift_reg)
            2'd0:    pp_aligned = PROD_W'(pp_reg);
            2'd1:    pp_aligned = PROD_W'(pp_reg) << HALF_W;
            2'd2:    pp_aligned = PROD_W'(pp_reg) << (2 * HALF_W);
            default: pp_aligned = '0;
        endcase
    end

    // Drop the fraction, clip to range and restore the sign
    assign mag_full = acc_reg[PROD_W-1:FRAC_BITS];
    assign lim      = neg_reg ? LIM_NEG : LIM_POS;
    assign over     = mag_full > lim;
    assign mag_clip = over ? lim[VAL_W-1:0] : mag_full[VAL_W-1:0];
    assign fin_val  = neg_reg ? (~mag_clip + VAL_W'(1)) : mag_clip;

    // Coordinate store and cursor
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int k = 0; k < 4; k++) begin
                coord_reg[k] <= COORD_WIDTH'(keep_in[k]);
            end
            cursor_reg <= '0;
        end else if (cmd.out_load && found_reg) begin
            cursor_reg <= cand_reg;
        end
    end

    // Term setup and cursor search
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            term_reg  <= cursor_reg;
            cand_reg  <= cursor_reg;
            found_reg <= 1'b0;
            exh_reg   <= 1'b0;
        end else if (cmd.search_step && !found_reg && !exh_reg) begin
            if (cand_wrap) begin
                exh_reg <= 1'b1;
            end else begin
                cand_reg  <= cand_inc;
                found_reg <= is_term(cand_inc);
            end
        end
    end

    // Multiply sequence
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rem_reg <= cursor_reg;
            val_reg <= ONE_VAL;
            sat_reg <= 1'b0;
        end
        if (cmd.setup) begin
            a_mag_reg <= vmag;
            b_mag_reg <= MAG_W'(cmag);
            neg_reg   <= val_reg[VAL_W-1] ^ csel[COORD_WIDTH-1];
            acc_reg   <= ACC_INIT;
        end
        if (cmd.mul) begin
            pp_reg       <= pp_next;
            pp_shift_reg <= shift_next;
        end
        if (cmd.acc) begin
            acc_reg <= acc_reg + pp_aligned;
        end
        if (cmd.fin) begin
            val_reg      <= fin_val;
            sat_reg      <= sat_reg | over;
            rem_reg[sel] <= rem_reg[sel] - EXP_W'(1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_val_reg  <= val_reg;
            out_exp_reg  <= term_reg;
            out_last_reg <= exh_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign status.steps_left  = (rem_reg != '0);
    assign status.search_done = found_reg || exh_reg;
    assign status.exhausted   = exh_reg;

    assign term_value = out_val_reg;
    assign exp_x      = out_exp_reg[3];
    assign exp_theta  = out_exp_reg[2];
    assign exp_y      = out_exp_reg[1];
    assign exp_phi    = out_exp_reg[0];
    assign last_term  = out_last_reg;
    assign saturated  = out_sat_reg;

endmodule

// ===== hw/rtl/mfg_ctrl.sv =====
// Controller: sequences load, multiply steps, term search and result handoff.
`timescale 1ns / 1ps

module mfg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  mfg_pkg::mfg_status_t status,
    output mfg_pkg::mfg_cmd_t    cmd
);
    import mfg_pkg::*;

    mfg_state_t        state_reg, state_next;
    logic [PART_W-1:0] part_reg, part_next;
    logic              event_loaded_reg, event_loaded_next;
    logic              terms_done_reg, terms_done_next;
    logic              m_valid_reg, m_valid_next;
    logic              s_fire;
    logic              out_free;
    logic              pull_ok;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign pull_ok  = s_fire && (s_command == CMD_NEXT) && event_loaded_reg && !terms_done_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (pull_ok) state_next = ST_CHECK;
            ST_CHECK:  state_next = status.steps_left ? ST_SETUP : ST_FINISH;
            ST_SETUP:  state_next = ST_MUL;
            ST_MUL:    if (part_reg == LAST_PART) state_next = ST_ACC;
            ST_ACC:    state_next = ST_FIN;
            ST_FIN:    state_next = ST_CHECK;
            ST_FINISH: if (status.search_done && out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd             = '0;
        cmd.part        = part_reg;
        cmd.search_step = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load  = s_fire && (s_command == CMD_LOAD);
                cmd.start = pull_ok;
            end
            ST_SETUP:  cmd.setup = 1'b1;
            ST_MUL: begin
                cmd.mul = 1'b1;
                cmd.acc = (part_reg != '0);
            end
            ST_ACC:    cmd.acc = 1'b1;
            ST_FIN:    cmd.fin = 1'b1;
            ST_FINISH: cmd.out_load = status.search_done && out_free;
            default: ;
        endcase
    end

    // Part counter, event flags and result valid
    always_comb begin
        part_next         = (state_reg == ST_MUL) ? part_reg + PART_W'(1) : '0;
        event_loaded_next = event_loaded_reg;
        terms_done_next   = terms_done_reg;
        if (cmd.load) begin
            event_loaded_next = 1'b1;
            terms_done_next   = 1'b0;
        end else if (cmd.out_load && status.exhausted) begin
            terms_done_next = 1'b1;
        end
        m_valid_next = cmd.out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            part_reg         <= '0;
            event_loaded_reg <= 1'b0;
            terms_done_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            part_reg         <= part_next;
            event_loaded_reg <= event_loaded_next;
            terms_done_reg   <= terms_done_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== verif/monomial_feature_generator_core_tb.sv =====
// Self-checking testbench for the monomial feature generator core.
`timescale 1ns / 1ps

module monomial_feature_generator_core_tb;

    localparam int EXP_CAP      = 5;
    localparam int ORDER_CAP    = 7;
    localparam int COORD_W      = 32;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_AFTER  = 380;
    localparam int DRAIN_CYCLES = 400;
    localparam int FRAC         = 30;

    localparam logic [31:0] Q30_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q30_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
    localparam logic [31:0] Q30_MONE = 32'hC000_0000;

    typedef struct {
        logic signed [mfg_pkg::VAL_W-1:0] value;
        logic [mfg_pkg::EXP_W-1:0]        ex;
        logic [mfg_pkg::EXP_W-1:0]        et;
        logic [mfg_pkg::EXP_W-1:0]        ey;
        logic [mfg_pkg::EXP_W-1:0]        ep;
        logic                             last;
        logic                             sat;
    } term_result_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_command;
    logic signed [mfg_pkg::IN_W-1:0]  s_x_in;
    logic signed [mfg_pkg::IN_W-1:0]  s_theta_in;
    logic signed [mfg_pkg::IN_W-1:0]  s_y_in;
    logic signed [mfg_pkg::IN_W-1:0]  s_phi_in;
    logic m_valid;
    logic m_ready;
    logic signed [mfg_pkg::VAL_W-1:0] m_term_value;
    logic [mfg_pkg::EXP_W-1:0]        m_exp_x;
    logic [mfg_pkg::EXP_W-1:0]        m_exp_theta;
    logic [mfg_pkg::EXP_W-1:0]        m_exp_y;
    logic [mfg_pkg::EXP_W-1:0]        m_exp_phi;
    logic                             m_last_term;
    logic                             m_saturated;

    // Predictor state: coordinates, term cursor (x, theta, y, phi) and flags
    logic signed [31:0] coord_q30 [4];
    int                 cursor_exp [4];
    bit                 event_armed;
    bit                 sweep_done;

    term_result_t expected_terms [$];
    int           mismatch_count;
    bit           idle_off;

    monomial_feature_generator_core #(
        .MAX_EXP     (EXP_CAP),
        .MAX_ORDER   (ORDER_CAP),
        .COORD_WIDTH (COORD_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_x_in       (s_x_in),
        .s_theta_in   (s_theta_in),
        .s_y_in       (s_y_in),
        .s_phi_in     (s_phi_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_term_value (m_term_value),
        .m_exp_x      (m_exp_x),
        .m_exp_theta  (m_exp_theta),
        .m_exp_y      (m_exp_y),
        .m_exp_phi    (m_exp_phi),
        .m_last_term  (m_last_term),
        .m_saturated  (m_saturated)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One Q30 multiply step: round half away from zero, then clip to 48 bits
    function automatic logic signed [63:0] q30_multiply(input logic signed [63:0] acc,
                                                        input logic signed [63:0] coord,
                                                        output logic clipped);
        logic         neg;
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] full;
        logic [127:0] mag;
        logic [127:0] limit;
        neg   = (acc < 0) != (coord < 0);
        mag_a = (acc < 0) ? -acc : acc;
        mag_b = (coord < 0) ? -coord : coord;
        full  = {64'd0, mag_a} * {64'd0, mag_b} + (128'd1 << (FRAC - 1));
        mag   = full >> FRAC;
        limit = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
        clipped = mag > limit;
        if (clipped) begin
            mag = limit;
        end
        return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
    endfunction

    function automatic bit is_valid_monomial(input int a, input int b, input int c,
                                             input int d);
        if (a > EXP_CAP || b > EXP_CAP || c > EXP_CAP || d > EXP_CAP) begin
            return 1'b0;
        end
        if (a + b + c + d > ORDER_CAP) begin
            return 1'b0;
        end
        // odd phi power needs theta power 1 or 2 and y power 0 or 1
        if ((d % 2) == 1 && !((b == 1 || b == 2) && (c == 0 || c == 1))) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the cursor to the next term, phi exponent counting fastest
    task automatic step_cursor(output bit more);
        int e [4];
        int k;
        bit found;
        e = cursor_exp;
        found = 1'b0;
        while (!found) begin
            for (k = 3; k >= 0; k--) begin
                if (e[k] < EXP_CAP) begin
                    e[k]++;
                    break;
                end
                e[k] = 0;
            end
            if (k < 0) begin
                break;
            end
            found = is_valid_monomial(e[0], e[1], e[2], e[3]);
        end
        if (found) begin
            cursor_exp = e;
        end
        more = found;
    endtask

    // Update the predictor with one accepted transfer and queue its result
    task automatic predict_transfer(input logic cmd, input logic [31:0] xv,
                                    input logic [31:0] tv, input logic [31:0] yv,
                                    input logic [31:0] pv);
        logic signed [63:0] acc;
        logic               clip;
        term_result_t       r;
        bit                 more;
        if (cmd == mfg_pkg::CMD_LOAD) begin
            coord_q30[0] = xv;
            coord_q30[1] = tv;
            coord_q30[2] = yv;
            coord_q30[3] = pv;
            cursor_exp   = '{0, 0, 0, 0};
            event_armed  = 1'b1;
            sweep_done   = 1'b0;
            return;
        end
        if (!event_armed || sweep_done) begin
            return;
        end
        acc   = 64'sd1 <<< FRAC;
        r.sat = 1'b0;
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < cursor_exp[k]; i++) begin
                acc   = q30_multiply(acc, coord_q30[k], clip);
                r.sat = r.sat | clip;
            end
        end
        r.value = acc[mfg_pkg::VAL_W-1:0];
        r.ex    = cursor_exp[0][mfg_pkg::EXP_W-1:0];
        r.et    = cursor_exp[1][mfg_pkg::EXP_W-1:0];
        r.ey    = cursor_exp[2][mfg_pkg::EXP_W-1:0];
        r.ep    = cursor_exp[3][mfg_pkg::EXP_W-1:0];
        step_cursor(more);
        r.last = !more;
        if (!more) begin
            sweep_done = 1'b1;
        end
        expected_terms.insert(expected_terms.size(), r);
    endtask

    // Drive one input transfer, wait for it to be taken, then maybe idle
    task automatic send_cmd(input logic cmd, input logic [31:0] xv, input logic [31:0] tv,
                            input logic [31:0] yv, input logic [31:0] pv);
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_x_in     <= xv;
        s_theta_in <= tv;
        s_y_in     <= yv;
        s_phi_in   <= pv;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_transfer(cmd, xv, tv, yv, pv);
        if (!idle_off && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge aclk);
        end
    endtask

    task automatic pull_term();
        send_cmd(mfg_pkg::CMD_NEXT, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return Q30_MAX;
            1:       return Q30_MIN;
            2:       return '0;
            3:       return Q30_ONE;
            4:       return Q30_MONE;
            5:       return $urandom() >> $urandom_range(1, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic load_random();
        send_cmd(mfg_pkg::CMD_LOAD, pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endtask

    // Pulls before any load must be dropped
    task automatic test_pull_before_load();
        pull_term();
        pull_term();
    endtask

    // Extreme coordinates, each later load rewinding a partly used event
    task automatic test_extreme_coords();
        send_cmd(mfg_pkg::CMD_LOAD, Q30_MAX, Q30_MAX, Q30_MAX, Q30_MAX);
        repeat (4) pull_term();
        send_cmd(mfg_pkg::CMD_LOAD, Q30_MIN, Q30_MIN, Q30_MIN, Q30_MIN);
        repeat (4) pull_term();
        send_cmd(mfg_pkg::CMD_LOAD, '0, 32'hFFFF_FFFF, Q30_ONE, Q30_MONE);
        repeat (3) pull_term();
        send_cmd(mfg_pkg::CMD_LOAD, Q30_MAX, Q30_MIN, Q30_MONE, Q30_MIN);
        repeat (4) pull_term();
    endtask

    // Walk one event through every term, pull past the end, then rewind
    task automatic test_full_sweep();
        load_random();
        while (!sweep_done) begin
            pull_term();
        end
        pull_term();
        pull_term();
        load_random();
        pull_term();
    endtask

    // Random events: mostly short partial walks, some full walks past the end
    task automatic test_random_events();
        int counted;
        int pulls;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            idle_off = counted >= QUIET_AFTER;
            load_random();
            counted++;
            pulls = ($urandom_range(0, 5) == 0) ? 240 : $urandom_range(0, 40);
            for (int n = 0; n < pulls && counted < RANDOM_ITEMS; n++) begin
                idle_off = counted >= QUIET_AFTER;
                counted++;
                pull_term();
            end
        end
    endtask

    // Randomly stall the result channel in bursts
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!idle_off && $urandom_range(0, 15) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transfer with the oldest expected term
    always @(posedge aclk) begin
        term_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_terms.size() == 0) begin
                $display({"%0t: result with none expected: expected nothing, ",
                          "actual %0d (%0d %0d %0d %0d)"},
                         $time, m_term_value, m_exp_x, m_exp_theta, m_exp_y, m_exp_phi);
                mismatch_count++;
            end else begin
                want = expected_terms.pop_front();
                check_field("term_value", want.value, m_term_value);
                check_field("exp_x", want.ex, m_exp_x);
                check_field("exp_theta", want.et, m_exp_theta);
                check_field("exp_y", want.ey, m_exp_y);
                check_field("exp_phi", want.ep, m_exp_phi);
                check_field("last_term", want.last, m_last_term);
                check_field("saturated", want.sat, m_saturated);
            end
        end
    end

    // Stop a hung run
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_command      = mfg_pkg::CMD_LOAD;
        s_x_in         = '0;
        s_theta_in     = '0;
        s_y_in         = '0;
        s_phi_in       = '0;
        mismatch_count = 0;
        idle_off       = 1'b0;
        event_armed    = 1'b0;
        sweep_done     = 1'b0;
        cursor_exp     = '{0, 0, 0, 0};
        for (int k = 0; k < 4; k++) begin
            coord_q30[k] = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_pull_before_load();
        test_extreme_coords();
        test_full_sweep();
        test_random_events();

        // Drain outstanding results, then watch for strays
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_terms.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mfg_pkg.sv
hw/rtl/mfg_datapath.sv
hw/rtl/mfg_ctrl.sv
hw/rtl/monomial_feature_generator_core.sv
verif/monomial_feature_generator_core_tb.sv
